/* design/assert_macros.svh */
// Assertion macros shared by the RTL of the multiply-with-carry generator.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* design/mwc_pkg.sv */
// Types and constants of the multiply-with-carry random number generator.
// No dependencies; imported by every module of the block.
package mwc_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned RANGE_W = 31;

    localparam logic [31:0] MUL_ONE        = 32'd36969;
    localparam logic [31:0] MUL_TWO        = 32'd18000;
    localparam logic [31:0] HALF_ZERO_SEED = 32'h0BAD_B002;
    localparam logic [31:0] ZERO_SEED_TWO  = 32'hDEAD_BEEF;
    localparam logic [31:0] ZERO_SEED_ONE  = 32'hCAFE_BABE;
    localparam logic [30:0] RAND_MAX_RST   = 31'd32768;
    localparam logic [30:0] RANGED_SAT     = 31'h7FFF_FFFF;

    typedef enum logic {
        REQ_DRAW   = 1'b0,
        REQ_RESEED = 1'b1
    } t_req;

    typedef enum logic {
        REG_RAND_MAX = 1'b0,
        REG_RAND_MIN = 1'b1
    } t_reg_idx;

    // Commands from the sequencer to the seed registers.
    typedef struct packed {
        logic        load;
        logic        step;
        logic [31:0] value;
    } t_seed_ctl;

    // Status and result of the serial remainder unit.
    typedef struct packed {
        logic        done;
        logic        neg;
        logic [30:0] rem;
    } t_div_res;

endpackage

/* design/mwc_seed_regs.sv */
// Seed pair of the generator: reseed loading and one cross-coupled MWC step.
// Depends on mwc_pkg.
module mwc_seed_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mwc_pkg::t_seed_ctl i_ctl,
    output logic [31:0]       o_raw
);
    import mwc_pkg::*;

    logic [31:0] r_seed_one, r_seed_two;
    logic [31:0] n_seed_one, n_seed_two;
    logic [31:0] s_one, s_two;
    logic [31:0] half;

    // A zero seed is forced to one before it is advanced.
    assign s_one = (r_seed_one == 32'd0) ? 32'd1 : r_seed_one;
    assign s_two = (r_seed_two == 32'd0) ? 32'd1 : r_seed_two;
    assign half  = {1'b0, i_ctl.value[31:1]};

    always_comb begin
        n_seed_one = r_seed_one;
        n_seed_two = r_seed_two;
        if (i_ctl.load) begin
            if (i_ctl.value != 32'd0) begin
                n_seed_two = i_ctl.value;
                n_seed_one = (half == 32'd0) ? HALF_ZERO_SEED : half;
            end else begin
                n_seed_two = ZERO_SEED_TWO;
                n_seed_one = ZERO_SEED_ONE;
            end
        end else if (i_ctl.step) begin
            n_seed_one = MUL_ONE * {16'h0000, s_one[15:0]} + {16'h0000, s_two[31:16]};
            n_seed_two = MUL_TWO * {16'h0000, s_two[15:0]} + {16'h0000, s_one[31:16]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_one <= 32'd1;
            r_seed_two <= 32'd1;
        end else begin
            r_seed_one <= n_seed_one;
            r_seed_two <= n_seed_two;
        end
    end

    assign o_raw = {r_seed_one[15:0], 16'h0000} + r_seed_two;

endmodule

/* design/mwc_serial_rem.sv */
// Bit-serial signed remainder: one restoring step per cycle over 32 dividend bits.
// Depends on mwc_pkg.
module mwc_serial_rem (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_dividend,
    input  logic [30:0]      i_divisor,
    output mwc_pkg::t_div_res o_res
);
    import mwc_pkg::*;

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [30:0] r_rem;
    logic        r_neg;
    logic [31:0] n_shift;
    logic [31:0] n_diff;
    logic        n_ge;
    logic [30:0] n_rem;
    logic [31:0] dividend_mag;

    assign dividend_mag = i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;

    // For a nonzero divisor the partial remainder stays below the divisor, so 31 bits hold it.
    assign n_shift = {r_rem, r_quo[31]};
    assign n_diff  = n_shift - {1'b0, i_divisor};
    assign n_ge    = (n_shift >= {1'b0, i_divisor});
    assign n_rem   = n_ge ? n_diff[30:0] : n_shift[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= dividend_mag;
            r_rem <= 31'd0;
            r_neg <= i_dividend[31];
        end else if (r_busy) begin
            r_quo <= {r_quo[30:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_res.done = r_done;
    assign o_res.neg  = r_neg;
    assign o_res.rem  = r_rem;

endmodule

/* design/mwc_random_generator.sv */
// Top level of the multiply-with-carry random number generator.
// Depends on mwc_pkg, mwc_seed_regs, mwc_serial_rem and assert_macros.svh.
//
// A reseed request loads the seeds on its input transfer and gives no result. A draw
// advances the seeds on its input transfer; the block then forms the raw word from
// the advanced seeds, starts the remainder unit, runs the bit-serial remainder by
// rand_max (one dividend bit a cycle), adds rand_min, takes the magnitude and loads
// the output register, waiting before that load while a previous result is held by
// a stalled output. The next request is taken once the block is back in idle, even
// while the previous result still waits in the output register. rand_max and
// rand_min may only be written while no draw is in progress.
module mwc_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_seed_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_raw_value,
    output logic [30:0] o_ranged_value
);
    import mwc_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_RAW    = 6'b000010,
        ST_DSTART = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_SUM    = 6'b010000,
        ST_FIN    = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [30:0] r_rand_max;
    logic [31:0] r_rand_min;
    logic [31:0] r_raw;
    logic [33:0] r_sum;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_raw_out;
    logic [30:0] r_ranged_out;

    t_seed_ctl   seed_ctl;
    logic [31:0] seed_raw;
    t_div_res    div_res;
    logic        in_xfer, out_xfer, out_load;
    logic [33:0] rem_signed, sum_base, mag;
    logic [30:0] ranged;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_out_valid && !i_out_stall;
    assign out_load   = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);

    assign seed_ctl.load  = in_xfer && (t_req'(i_req_type) == REQ_RESEED);
    assign seed_ctl.step  = in_xfer && (t_req'(i_req_type) == REQ_DRAW);
    assign seed_ctl.value = i_seed_value;

    mwc_seed_regs u_seed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (seed_ctl),
        .o_raw   (seed_raw)
    );

    mwc_serial_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DSTART),
        .i_dividend (r_raw),
        .i_divisor  (r_rand_max),
        .o_res      (div_res)
    );

    // A zero divisor passes the signed raw word through unchanged.
    assign rem_signed = div_res.neg ? (34'd0 - {3'b000, div_res.rem})
                                    : {3'b000, div_res.rem};
    assign sum_base   = (r_rand_max == 31'd0) ? {{2{r_raw[31]}}, r_raw} : rem_signed;

    assign mag    = r_sum[33] ? (34'd0 - r_sum) : r_sum;
    assign ranged = (mag[33:31] != 3'b000) ? RANGED_SAT : mag[30:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (seed_ctl.step) n_state = ST_RAW;
            ST_RAW:    n_state = ST_DSTART;
            ST_DSTART: n_state = ST_DIV;
            ST_DIV:    if (div_res.done) n_state = ST_SUM;
            ST_SUM:    n_state = ST_FIN;
            ST_FIN:    if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (out_xfer) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rand_max  <= RAND_MAX_RST;
            r_rand_min  <= 32'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_RAND_MAX: r_rand_max <= i_cfg_wdata[30:0];
                    REG_RAND_MIN: r_rand_min <= i_cfg_wdata;
                    default:      r_rand_min <= r_rand_min;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RAW) begin
            r_raw <= seed_raw;
        end
        if (r_state == ST_DIV && div_res.done) begin
            r_sum <= sum_base + {{2{r_rand_min[31]}}, r_rand_min};
        end
        if (out_load) begin
            r_raw_out    <= r_raw;
            r_ranged_out <= ranged;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_raw_value    = r_raw_out;
    assign o_ranged_value = r_ranged_out;

    `ASSERT_NEXT(a_draw_starts, i_clk, i_rst_n, seed_ctl.step, r_state == ST_RAW)
    `ASSERT_SAME(a_done_in_div, i_clk, i_rst_n, div_res.done, r_state == ST_DIV)
    `ASSERT_SAME(a_result_from_fin, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == ST_FIN))

endmodule
